### hdl/bba_pkg.sv
package bba_pkg;

	localparam int NUM_BLOCKS_DEF = 256;

	localparam int OPCODE_W = 3;
	localparam int COUNT_W  = 9;
	localparam int START_W  = 8;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 8;
	localparam int CFG_W    = 9;

	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

	localparam logic [OPCODE_W-1:0] OP_CLAIM_ONE     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_CLAIM_RUN     = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_RELEASE_RANGE = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_RELEASE_FIRST = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CLEAR         = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLIPPED  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start; // latch a new command and set up the scan window
		logic init;  // the new command is the clearing pass after reset
		logic scan;  // scan window may issue reads and evaluate blocks
		logic fill;  // mark one block of the found run occupied
		logic push;  // load the result into the output register
	} bba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic need_fill;
		logic fill_last;
	} bba_sts_t;

endpackage

### hdl/bba_ctrl.sv
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bba_pkg::bba_cmd_t cmd,
	input  bba_pkg::bba_sts_t sts
);
	import bba_pkg::*;

	localparam logic [2:0] S_INIT_GO   = 3'd0;
	localparam logic [2:0] S_INIT_SCAN = 3'd1;
	localparam logic [2:0] S_IDLE      = 3'd2;
	localparam logic [2:0] S_SCAN      = 3'd3;
	localparam logic [2:0] S_FILL      = 3'd4;
	localparam logic [2:0] S_HOLD      = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd.start = (state_q == S_INIT_GO) || ((state_q == S_IDLE) && in_valid);
		cmd.init  = (state_q == S_INIT_GO);
		cmd.scan  = (state_q == S_INIT_SCAN) || (state_q == S_SCAN);
		cmd.fill  = (state_q == S_FILL);
		cmd.push  = (state_q == S_HOLD) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT_GO: begin
				state_d = S_INIT_SCAN;
			end
			S_INIT_SCAN: begin
				if (sts.scan_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = sts.need_fill ? S_FILL : S_HOLD;
			end
			S_FILL: begin
				if (sts.fill_last) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (cmd.push) state_d = S_IDLE;
			end
			default: begin
				state_d = S_INIT_GO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT_GO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

### hdl/bba_dp.sv
module bba_dp #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
	input  logic [bba_pkg::OPCODE_W-1:0]    opcode,
	input  logic [bba_pkg::COUNT_W-1:0]     block_count,
	input  logic [bba_pkg::START_W-1:0]     start_block,
	input  bba_pkg::bba_cmd_t               cmd,
	output bba_pkg::bba_sts_t               sts,
	output logic [bba_pkg::STATUS_W-1:0]    status,
	output logic [bba_pkg::INDEX_W-1:0]     block_index,
	output logic [bba_pkg::COUNT_W-1:0]     blocks_changed
);
	import bba_pkg::*;

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
	localparam logic [CW-1:0] DEPTH = CW'(NUM_BLOCKS);

	logic map_mem [NUM_BLOCKS];

	logic [CFG_W-1:0]    biu_q;
	logic [CW-1:0]       managed;
	logic [OPCODE_W-1:0] op_sel;
	logic [COUNT_W-1:0]  cnt_sel;
	logic [CW-1:0]       range_end;
	logic [CW-1:0]       begin_d;
	logic [CW-1:0]       end_d;

	logic [OPCODE_W-1:0] op_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic                clip_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       end_q;
	logic                hit_q;
	logic [COUNT_W-1:0]  run_len_q;
	logic [CW-1:0]       run_start_q;
	logic [COUNT_W-1:0]  chg_q;
	logic [COUNT_W-1:0]  fill_ofs_q;

	logic                vld_s1;
	logic [CW-1:0]       pos_s1;
	logic                bit_s1;

	logic                issue;
	logic                ev;
	logic                hit_n;
	logic [COUNT_W-1:0]  run_len_n;
	logic [CW-1:0]       run_start_n;
	logic [COUNT_W-1:0]  chg_n;
	logic                we;
	logic [AW-1:0]       wa;
	logic                wd;
	logic [CW-1:0]       fill_addr;

	logic [STATUS_W-1:0] res_status;
	logic [INDEX_W-1:0]  res_index;
	logic [COUNT_W-1:0]  res_changed;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  index_q;
	logic [COUNT_W-1:0]  changed_q;

	assign managed = (CW'(biu_q) > DEPTH) ? DEPTH : CW'(biu_q);

	// Scan window of the new command.
	always_comb begin
		op_sel    = cmd.init ? OP_CLEAR : opcode;
		cnt_sel   = cmd.init ? '0 : block_count;
		range_end = CW'(start_block) + CW'(block_count);
		begin_d   = '0;
		end_d     = '0;
		case (op_sel)
			OP_CLAIM_ONE: begin
				end_d = managed;
			end
			OP_CLAIM_RUN: begin
				if ((cnt_sel != '0) && (CW'(cnt_sel) <= managed)) end_d = managed;
			end
			OP_RELEASE_RANGE: begin
				begin_d = CW'(start_block);
				end_d   = (range_end > managed) ? managed : range_end;
			end
			OP_RELEASE_FIRST: begin
				if (cnt_sel != '0) end_d = managed;
			end
			OP_CLEAR: begin
				end_d = DEPTH;
			end
			default: begin
				end_d = '0;
			end
		endcase
	end

	assign issue = cmd.scan && !hit_q && (pos_q < end_q);
	assign ev    = vld_s1 && !hit_q;

	// Evaluation of the block whose bit returned from the map.
	always_comb begin
		hit_n       = 1'b0;
		run_len_n   = run_len_q;
		run_start_n = run_start_q;
		chg_n       = chg_q;
		we          = 1'b0;
		wa          = pos_s1[AW-1:0];
		wd          = 1'b0;
		if (ev) begin
			case (op_q)
				OP_CLAIM_ONE: begin
					if (!bit_s1) begin
						we          = 1'b1;
						wd          = 1'b1;
						hit_n       = 1'b1;
						run_start_n = pos_s1;
						chg_n       = COUNT_W'(1);
					end
				end
				OP_CLAIM_RUN: begin
					if (!bit_s1) begin
						if (COUNT_W'(run_len_q + 9'd1) == cnt_q) hit_n = 1'b1;
						else run_len_n = COUNT_W'(run_len_q + 9'd1);
					end else begin
						run_len_n   = '0;
						run_start_n = CW'(pos_s1 + CW'(1));
					end
				end
				OP_RELEASE_RANGE: begin
					if (bit_s1) begin
						we    = 1'b1;
						chg_n = COUNT_W'(chg_q + 9'd1);
					end
				end
				OP_RELEASE_FIRST: begin
					if (bit_s1) begin
						we    = 1'b1;
						chg_n = COUNT_W'(chg_q + 9'd1);
						if (COUNT_W'(chg_q + 9'd1) == cnt_q) hit_n = 1'b1;
					end
				end
				OP_CLEAR: begin
					we = 1'b1;
					if (bit_s1) chg_n = COUNT_W'(chg_q + 9'd1);
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end else if (cmd.fill) begin
			we = 1'b1;
			wd = 1'b1;
			wa = fill_addr[AW-1:0];
		end
	end

	assign fill_addr = CW'(run_start_q + CW'(fill_ofs_q));

	always_ff @(posedge clk) begin
		if (we) map_mem[wa] <= wd;
		if (issue) bit_s1 <= map_mem[pos_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q       <= CFG_RESET;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			pos_q       <= '0;
			end_q       <= '0;
		end else begin
			if (cfg_valid) biu_q <= cfg_data;
			vld_s1 <= issue;
			if (cmd.start) begin
				hit_q <= 1'b0;
				pos_q <= begin_d;
				end_q <= end_d;
			end else begin
				if (hit_n) hit_q <= 1'b1;
				if (issue) pos_q <= CW'(pos_q + CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) pos_s1 <= pos_q;
		if (cmd.start) begin
			op_q        <= op_sel;
			cnt_q       <= cnt_sel;
			clip_q      <= (range_end > managed);
			run_len_q   <= '0;
			run_start_q <= begin_d;
			chg_q       <= '0;
			fill_ofs_q  <= '0;
		end else begin
			run_len_q   <= run_len_n;
			run_start_q <= run_start_n;
			chg_q       <= chg_n;
			if (cmd.fill) fill_ofs_q <= COUNT_W'(fill_ofs_q + 9'd1);
		end
	end

	always_comb begin
		res_status  = ST_DONE;
		res_index   = '0;
		res_changed = chg_q;
		case (op_q)
			OP_CLAIM_ONE: begin
				res_status = hit_q ? ST_DONE : ST_NO_SPACE;
				if (hit_q) res_index = run_start_q[INDEX_W-1:0];
			end
			OP_CLAIM_RUN: begin
				res_status  = ((cnt_q == '0) || hit_q) ? ST_DONE : ST_NO_SPACE;
				res_changed = hit_q ? cnt_q : '0;
				if (hit_q) res_index = run_start_q[INDEX_W-1:0];
			end
			OP_RELEASE_RANGE: begin
				res_status = clip_q ? ST_CLIPPED : ST_DONE;
			end
			default: begin
				res_status = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			status_q  <= res_status;
			index_q   <= res_index;
			changed_q <= res_changed;
		end
	end

	always_comb begin
		sts.scan_done = hit_q || (!vld_s1 && !(pos_q < end_q));
		sts.need_fill = hit_q && (op_q == OP_CLAIM_RUN);
		sts.fill_last = (COUNT_W'(fill_ofs_q + 9'd1) == cnt_q);
	end

	assign status         = status_q;
	assign block_index    = index_q;
	assign blocks_changed = changed_q;

endmodule

### hdl/block_bitmap_allocator.sv
// Channel  | Handshake                     | Carries
// ---------+-------------------------------+---------------------------------------------
// cfg      | cfg_valid / cfg_ready         | cfg_data: blocks_in_use
// in       | in_valid / in_ready           | opcode, block_count, start_block
// out      | out_valid / out_ready         | status, block_index, blocks_changed
//
// A command scans the map one block per cycle over its window (the managed blocks, or the
// release range); a successful run claim then marks the claimed blocks one by one, and
// clear always sweeps all NUM_BLOCKS entries.
// After reset in_ready stays low while a clearing pass zeroes the map.
// The result sits in an output register, so a new command is taken while it waits; a
// command that finishes while that register is still full stalls until it is taken.
module block_bitmap_allocator #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bba_pkg::OPCODE_W-1:0]    opcode,
	input  logic [bba_pkg::COUNT_W-1:0]     block_count,
	input  logic [bba_pkg::START_W-1:0]     start_block,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bba_pkg::STATUS_W-1:0]    status,
	output logic [bba_pkg::INDEX_W-1:0]     block_index,
	output logic [bba_pkg::COUNT_W-1:0]     blocks_changed
);
	import bba_pkg::*;

	bba_cmd_t cmd;
	bba_sts_t sts;

	// The count register is only sampled when a command starts, so a transfer on the
	// configuration channel is always taken at once.
	assign cfg_ready = 1'b1;

	// The controller sequences the clearing pass, the scan, the run fill and the result
	// transfer; it never looks at the map itself.
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the map memory, the scan counters and the output register.
	bba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.block_count    (block_count),
		.start_block    (start_block),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.block_index    (block_index),
		.blocks_changed (blocks_changed)
	);

endmodule

### hdl/bba_chk.sv
module bba_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [bba_pkg::STATUS_W-1:0]    status,
	input logic [bba_pkg::INDEX_W-1:0]     block_index,
	input logic [bba_pkg::COUNT_W-1:0]     blocks_changed
);
	import bba_pkg::*;

	// A result that is not taken holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block_index)
			&& $stable(blocks_changed))
		else $error("result changed while stalled");

	// Only one command is in work at a time.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while one is in work");

	// A failed claim changes nothing.
	a_no_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_SPACE) |-> (block_index == '0) && (blocks_changed == '0))
		else $error("failed claim reports a change");

	// Only the defined status codes appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE) || (status == ST_NO_SPACE) || (status == ST_CLIPPED))
		else $error("undefined status code");

	// A clipped release never names a claimed block.
	a_clip_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_CLIPPED) |-> (block_index == '0))
		else $error("clipped release with nonzero index");

endmodule

bind block_bitmap_allocator bba_chk u_bba_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.block_index    (block_index),
	.blocks_changed (blocks_changed)
);

### tb/sv/block_bitmap_allocator_tb.sv
module block_bitmap_allocator_tb;
	import bba_pkg::*;

	localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;

	// The opcodes above clear do nothing in the block. They still answer with a
	// plain done result, so the stimulus sends them now and then.
	localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = OP_CLEAR + 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

	// The longest command is a full run claim over 256 blocks: one scan over the
	// map plus one fill per claimed block. The tail wait covers that.
	localparam int TAIL_CYCLES   = 600;
	localparam int TIMEOUT       = 20_000_000;
	localparam int LONG_HOLD_AT  = 60;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_PHASE  = 75;
	localparam int MAX_PRINTED   = 50;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [COUNT_W-1:0]  count;
		logic [START_W-1:0]  start;
	} alloc_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
		logic [COUNT_W-1:0]  changed;
	} alloc_result_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data       = '0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode         = '0;
	logic [COUNT_W-1:0]  block_count    = '0;
	logic [START_W-1:0]  start_block    = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  block_index;
	logic [COUNT_W-1:0]  blocks_changed;

	block_bitmap_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.block_count   (block_count),
		.start_block   (start_block),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.block_index   (block_index),
		.blocks_changed(blocks_changed)
	);

	always #6 clk = ~clk;

	// Our own copy of the allocation map and of the managed-count register.
	// The map starts all free, which is what the clearing pass after reset leaves.
	logic [NUM_BLOCKS-1:0] block_used     = '0;
	logic [CFG_W-1:0]      managed_blocks = CFG_RESET;

	alloc_cmd_t    cmd_queue[$];
	alloc_result_t pending_results[$];

	int mismatches      = 0;
	int results_checked = 0;
	int settings_used   = 1;
	int op_seen[8]      = '{default: 0};

	int send_gap  = 0;
	int send_calm = 0;
	int recv_gap  = 0;
	int recv_calm = 0;
	int hold_left = 0;

	logic         offer;
	logic         drain;
	alloc_cmd_t   taken_cmd;
	alloc_cmd_t   next_cmd;
	alloc_result_t wanted;

	// Applies one command to the local map and returns the result the block must give.
	// Only blocks below the managed count (saturated at the map depth) take part,
	// except for clear, which counts and zeroes every bit of the map.
	function automatic alloc_result_t apply_command(input alloc_cmd_t c);
		alloc_result_t r;
		int n;
		int i;
		int j;
		int run_len;
		int stop;
		int freed;
		logic found;
		r = '0;
		n = (managed_blocks > NUM_BLOCKS) ? NUM_BLOCKS : int'(managed_blocks);
		found = 1'b0;
		freed = 0;
		case (c.opcode)
			OP_CLAIM_ONE: begin
				r.status = ST_NO_SPACE;
				for (i = 0; i < n && !found; i++) begin
					if (!block_used[i]) begin
						block_used[i] = 1'b1;
						r.status = ST_DONE;
						r.index = i[INDEX_W-1:0];
						r.changed = COUNT_W'(1);
						found = 1'b1;
					end
				end
			end
			OP_CLAIM_RUN: begin
				// A run of zero is a no-op that still reports done.
				if (c.count != 0) begin
					r.status = ST_NO_SPACE;
					run_len = 0;
					for (i = 0; i < n && !found; i++) begin
						run_len = block_used[i] ? 0 : run_len + 1;
						if (run_len == c.count) begin
							for (j = i - run_len + 1; j <= i; j++)
								block_used[j] = 1'b1;
							r.status = ST_DONE;
							r.index = INDEX_W'(i - run_len + 1);
							r.changed = c.count;
							found = 1'b1;
						end
					end
				end
			end
			OP_RELEASE_RANGE: begin
				stop = int'(c.start) + int'(c.count);
				if (stop > n) begin
					r.status = ST_CLIPPED;
					stop = n;
				end
				for (i = int'(c.start); i < stop; i++) begin
					if (block_used[i]) begin
						block_used[i] = 1'b0;
						freed++;
					end
				end
				r.changed = COUNT_W'(freed);
			end
			OP_RELEASE_FIRST: begin
				for (i = 0; i < n && freed < c.count; i++) begin
					if (block_used[i]) begin
						block_used[i] = 1'b0;
						freed++;
					end
				end
				r.changed = COUNT_W'(freed);
			end
			OP_CLEAR: begin
				r.changed = COUNT_W'($countones(block_used));
				block_used = '0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Gap lengths for both sides: mostly none or short, a few long, and now and
	// then a calm stretch of back-to-back transfers.
	function automatic int pick_gap(inout int calm);
		int pick;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		pick = $urandom_range(99);
		if (pick < 4) begin
			calm = $urandom_range(40, 15);
			return 0;
		end
		if (pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(3, 1);
		if (pick < 96)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Random commands for a map of n managed blocks. Claims outweigh releases so
	// that the map fills and fragments; sizes are mostly modest against n, and a
	// share of counts and starts is drawn over the whole field.
	function automatic alloc_cmd_t random_cmd(input int n);
		alloc_cmd_t c;
		int pick;
		int span;
		span = (n >= 16) ? n / 8 : n;
		if (span < 1)
			span = 1;
		c.opcode = OP_CLAIM_ONE;
		c.count = COUNT_W'($urandom_range(511));
		c.start = START_W'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 32) begin
			c.opcode = OP_CLAIM_ONE;
		end else if (pick < 56) begin
			c.opcode = OP_CLAIM_RUN;
			if ($urandom_range(9) < 8)
				c.count = COUNT_W'($urandom_range(span, 1));
		end else if (pick < 76) begin
			c.opcode = OP_RELEASE_RANGE;
			if ($urandom_range(4) != 0) begin
				c.start = START_W'($urandom_range(n - 1));
				c.count = COUNT_W'($urandom_range(span, 0));
			end
		end else if (pick < 88) begin
			c.opcode = OP_RELEASE_FIRST;
			if ($urandom_range(4) != 0)
				c.count = COUNT_W'($urandom_range(span, 0));
		end else if (pick < 92) begin
			c.opcode = OP_CLEAR;
		end else begin
			c.opcode = OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		end
		return c;
	endfunction

	task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input int cnt, input int first);
		alloc_cmd_t c;
		c.opcode = op;
		c.count = COUNT_W'(cnt);
		c.start = START_W'(first);
		cmd_queue.push_back(c);
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t: result %0d: %s", $time, results_checked, msg);
	endtask

	// Waits until the sender has nothing left and every expected result has been
	// taken. Sampling on the falling edge keeps this free of races with the
	// clocked processes.
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
	endtask

	// One transfer on the configuration channel. Our copy of the register changes
	// at the edge where the transfer happens; the block is idle at that point.
	task automatic write_blocks_in_use(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		managed_blocks = value;
		cfg_valid <= 1'b0;
		settings_used++;
		@(negedge clk);
	endtask

	// Sender. Each accepted transfer is predicted right away, in the order the
	// block accepts them. Valid is assigned once per edge, so a command that
	// follows back to back keeps valid high without a drop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			block_count <= '0;
			start_block <= '0;
			send_gap = 0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				taken_cmd.opcode = opcode;
				taken_cmd.count = block_count;
				taken_cmd.start = start_block;
				pending_results.push_back(apply_command(taken_cmd));
				op_seen[opcode]++;
				offer = 1'b0;
				send_gap = pick_gap(send_calm);
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_queue.size() > 0) begin
					next_cmd = cmd_queue.pop_front();
					opcode <= next_cmd.opcode;
					block_count <= next_cmd.count;
					start_block <= next_cmd.start;
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// Receiver. Every result transfer is checked against the oldest expectation.
	// Once, after a fixed number of results, ready is held low for a long stretch
	// while the sender keeps going, so the output register fills and the block
	// has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			drain = out_ready;
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status=%0d index=%0d changed=%0d",
						status, block_index, blocks_changed));
				end else begin
					wanted = pending_results.pop_front();
					if (status !== wanted.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, wanted.status));
					if (block_index !== wanted.index)
						report_mismatch($sformatf("block_index %0d, expected %0d",
							block_index, wanted.index));
					if (blocks_changed !== wanted.changed)
						report_mismatch($sformatf("blocks_changed %0d, expected %0d",
							blocks_changed, wanted.changed));
				end
				results_checked++;
				recv_gap = pick_gap(recv_calm);
				if (results_checked == LONG_HOLD_AT)
					hold_left = LONG_HOLD;
				drain = 1'b0;
			end
			if (!drain) begin
				if (hold_left > 0)
					hold_left--;
				else if (recv_gap > 0)
					recv_gap--;
				else
					drain = 1'b1;
			end
			out_ready <= drain;
		end
	end

	// Stimulus. Each phase runs under one managed count; between phases the
	// sender pauses until every expected result is back before the count is
	// rewritten.
	initial begin
		int random_settings[6];
		int eff;
		int k;
		int unused_ops;
		random_settings = '{1, 511, 16, 256, 300, 0};
		random_settings[5] = $urandom_range(255, 2);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full map at the reset value. A run as long as the map fails once one
		// block is taken; a run of zero does nothing; the rest of the map is then
		// claimed in one run so that a single claim finds no room. A release range
		// past the end is clipped, and release-first asks for more than there is.
		// Runs longer than the managed count and the spare opcodes come next.
		queue_cmd(OP_CLAIM_ONE, 0, 0);
		queue_cmd(OP_CLAIM_RUN, 256, 0);
		queue_cmd(OP_CLAIM_RUN, 0, 0);
		queue_cmd(OP_CLAIM_RUN, 255, 0);
		queue_cmd(OP_CLAIM_ONE, 511, 255);
		queue_cmd(OP_RELEASE_RANGE, 256, 255);
		queue_cmd(OP_RELEASE_FIRST, 511, 0);
		queue_cmd(OP_CLAIM_RUN, 257, 0);
		queue_cmd(OP_SPARE_FIRST, 511, 255);
		queue_cmd(OP_SPARE_LAST, 0, 0);
		queue_cmd(OP_CLAIM_RUN, 4, 0);
		queue_cmd(OP_CLEAR, 0, 0);
		wait_idle();

		// Six blocks: fill them, punch a hole of two, fail a run of three, clip a
		// release past the end, then refill the hole.
		write_blocks_in_use(9'd6);
		queue_cmd(OP_CLAIM_RUN, 6, 0);
		queue_cmd(OP_CLAIM_ONE, 0, 0);
		queue_cmd(OP_RELEASE_RANGE, 2, 2);
		queue_cmd(OP_CLAIM_RUN, 3, 0);
		queue_cmd(OP_RELEASE_RANGE, 200, 3);
		queue_cmd(OP_CLAIM_RUN, 2, 0);
		wait_idle();

		// Shrink to two blocks while blocks two and three stay occupied. Commands
		// must leave those alone; only clear sees and zeroes them.
		write_blocks_in_use(9'd2);
		queue_cmd(OP_RELEASE_FIRST, 511, 0);
		queue_cmd(OP_CLAIM_RUN, 2, 0);
		queue_cmd(OP_RELEASE_RANGE, 256, 0);
		queue_cmd(OP_CLEAR, 0, 0);
		wait_idle();

		// No managed blocks at all: claims find no room and only an empty release
		// range escapes being clipped.
		write_blocks_in_use(9'd0);
		queue_cmd(OP_CLAIM_ONE, 0, 0);
		queue_cmd(OP_CLAIM_RUN, 1, 0);
		queue_cmd(OP_RELEASE_RANGE, 0, 0);
		queue_cmd(OP_RELEASE_RANGE, 1, 5);
		queue_cmd(OP_RELEASE_FIRST, 3, 0);
		wait_idle();

		// Random phases, including a single block, counts above the map depth that
		// must saturate, and the full map.
		foreach (random_settings[p]) begin
			write_blocks_in_use(CFG_W'(random_settings[p]));
			eff = (random_settings[p] > NUM_BLOCKS) ? NUM_BLOCKS : random_settings[p];
			for (k = 0; k < RANDOM_PHASE; k++)
				cmd_queue.push_back(random_cmd(eff));
			wait_idle();
		end

		// Anything the block still sends now has no expectation and is caught by
		// the receiver.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_results.size()));

		unused_ops = 0;
		for (k = int'(OP_SPARE_FIRST); k <= int'(OP_SPARE_LAST); k++)
			unused_ops += op_seen[k];
		$display("Sent %0d claim-one, %0d claim-run, %0d release-range, %0d release-first,",
			op_seen[OP_CLAIM_ONE], op_seen[OP_CLAIM_RUN], op_seen[OP_RELEASE_RANGE],
			op_seen[OP_RELEASE_FIRST]);
		$display("%0d clear and %0d spare-opcode commands; %0d results checked under %0d counts.",
			op_seen[OP_CLEAR], unused_ops, results_checked, settings_used);
		if (mismatches == 0) begin
			$display("block_bitmap_allocator test passed");
		end else begin
			$display("block_bitmap_allocator test failed");
		end
		$finish;
	end

	// Watchdog: generous against the slowest legal run, including the clearing
	// pass after reset and the long receiver hold.
	initial begin
		#(TIMEOUT);
		$display("block_bitmap_allocator test failed");
		$finish;
	end

endmodule
